// ----- src/imp_pkg.sv -----
// ----------------------------------------------------------------------------
// imp_pkg
// Shared types and constants for the integer matrix product block.
// ----------------------------------------------------------------------------
package imp_pkg;

    localparam int MAX_DIM_DEF = 64;
    localparam int DATA_W      = 32;
    localparam int POS_W       = 6;
    localparam int CFG_W       = 7;
    localparam int OP_W        = 2;
    localparam int REG_IDX_W   = 2;

    localparam logic [OP_W-1:0] OP_LOAD_A = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_B = 2'd1;
    localparam logic [OP_W-1:0] OP_PROD   = 2'd2;
    localparam logic [OP_W-1:0] OP_ELEM   = 2'd3;

    localparam logic [REG_IDX_W-1:0] REG_ROWS_A    = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_INNER_DIM = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_COLS_B    = 2'd2;

    typedef struct packed {
        logic clear;
        logic valid;
    } mac_ctrl_t;

endpackage

// ----- src/integer_matrix_product.sv -----
// ----------------------------------------------------------------------------
// integer_matrix_product
// Stores matrices A and B and answers product or elementwise queries.
//
// Loads (opcode 0 and 1) write one element and give no result beat. A
// product query reads A[row][k] and B[k][col] from the two element
// memories once per cycle over k and streams them through a single
// multiply-accumulate unit; a query outside rows_a or cols_b answers with
// status 1. The block takes no new item while a query is in progress; a
// finished result waits in the output register, and the next result leaves
// the sequencer only once that register is free. Memories are not cleared:
// a query must only touch elements that have been loaded.
// ----------------------------------------------------------------------------
module integer_matrix_product
    import imp_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [OP_W-1:0]             opcode,
    input  logic [POS_W-1:0]            row,
    input  logic [POS_W-1:0]            col,
    input  logic signed [DATA_W-1:0]    value,

    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [POS_W-1:0]            out_row,
    output logic [POS_W-1:0]            out_col,
    output logic signed [DATA_W-1:0]    out_value,
    output logic                        status,

    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [REG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_W-1:0]            cfg_data
);

    localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int ADDR_W = 2 * IDX_W;
    localparam int DEPTH  = 1 << ADDR_W;
    localparam int CMP_W  = IDX_W + 8;
    localparam logic [CMP_W-1:0] DIM_LIMIT = CMP_W'(MAX_DIM);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RUN   = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [CFG_W-1:0]  rows_a_reg;
    logic [CFG_W-1:0]  inner_dim_reg;
    logic [CFG_W-1:0]  cols_b_reg;
    logic [CFG_W-1:0]  nr_lim;
    logic [CFG_W-1:0]  nk_lim;
    logic [CFG_W-1:0]  nc_lim;

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic [CFG_W-1:0]  k_reg;
    logic [CFG_W-1:0]  k_next;
    logic [CFG_W-1:0]  count_reg;
    logic [CFG_W-1:0]  count_next;
    logic              rd_valid_reg;
    logic              out_valid_reg;

    logic [POS_W-1:0]  q_row_reg;
    logic [POS_W-1:0]  q_col_reg;
    logic              q_err_reg;
    logic              q_elem_reg;

    logic [POS_W-1:0]  out_row_reg;
    logic [POS_W-1:0]  out_col_reg;
    logic [DATA_W-1:0] out_value_reg;
    logic              status_reg;

    logic              in_accept;
    logic              is_load;
    logic              load_in_range;
    logic              query_err;
    logic              mem_a_we;
    logic              mem_b_we;
    logic              load_out;

    logic [IDX_W+POS_W-1:0] row_wide;
    logic [IDX_W+POS_W-1:0] col_wide;
    logic [IDX_W+POS_W-1:0] q_row_wide;
    logic [IDX_W+POS_W-1:0] q_col_wide;
    logic [IDX_W+CFG_W-1:0] k_wide;
    logic [ADDR_W-1:0]      addr_a;
    logic [ADDR_W-1:0]      addr_b;

    logic [DATA_W-1:0] mem_a [DEPTH];
    logic [DATA_W-1:0] mem_b [DEPTH];
    logic [DATA_W-1:0] rd_a_reg;
    logic [DATA_W-1:0] rd_b_reg;

    mac_ctrl_t         mac_ctrl;
    logic              mac_busy;
    logic [DATA_W-1:0] mac_acc;

    // a register value above MAX_DIM acts as MAX_DIM
    assign nr_lim = ({(CMP_W-CFG_W)'(0), rows_a_reg} > DIM_LIMIT)
                    ? CFG_W'(MAX_DIM) : rows_a_reg;
    assign nk_lim = ({(CMP_W-CFG_W)'(0), inner_dim_reg} > DIM_LIMIT)
                    ? CFG_W'(MAX_DIM) : inner_dim_reg;
    assign nc_lim = ({(CMP_W-CFG_W)'(0), cols_b_reg} > DIM_LIMIT)
                    ? CFG_W'(MAX_DIM) : cols_b_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_a_reg    <= CFG_W'(64);
            inner_dim_reg <= CFG_W'(64);
            cols_b_reg    <= CFG_W'(64);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_ROWS_A:    rows_a_reg    <= cfg_data;
                REG_INNER_DIM: inner_dim_reg <= cfg_data;
                REG_COLS_B:    cols_b_reg    <= cfg_data;
                default:       ;
            endcase
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign is_load   = (opcode == OP_LOAD_A) || (opcode == OP_LOAD_B);

    assign row_wide   = {{IDX_W{1'b0}}, row};
    assign col_wide   = {{IDX_W{1'b0}}, col};
    assign q_row_wide = {{IDX_W{1'b0}}, q_row_reg};
    assign q_col_wide = {{IDX_W{1'b0}}, q_col_reg};
    assign k_wide     = {{IDX_W{1'b0}}, k_reg};

    // drop loads that fall outside the store
    assign load_in_range = ({(CMP_W-POS_W)'(0), row} < DIM_LIMIT)
                        && ({(CMP_W-POS_W)'(0), col} < DIM_LIMIT);
    assign query_err = ({1'b0, row} >= nr_lim) || ({1'b0, col} >= nc_lim);

    assign mem_a_we = in_accept && (opcode == OP_LOAD_A) && load_in_range;
    assign mem_b_we = in_accept && (opcode == OP_LOAD_B) && load_in_range;

    always_comb
    begin
        if (state_reg == S_IDLE)
        begin
            addr_a = {row_wide[IDX_W-1:0], col_wide[IDX_W-1:0]};
            addr_b = {row_wide[IDX_W-1:0], col_wide[IDX_W-1:0]};
        end
        else if (q_elem_reg)
        begin
            addr_a = {q_row_wide[IDX_W-1:0], q_col_wide[IDX_W-1:0]};
            addr_b = {q_row_wide[IDX_W-1:0], q_col_wide[IDX_W-1:0]};
        end
        else
        begin
            addr_a = {q_row_wide[IDX_W-1:0], k_wide[IDX_W-1:0]};
            addr_b = {k_wide[IDX_W-1:0], q_col_wide[IDX_W-1:0]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_a_we)
        begin
            mem_a[addr_a] <= value;
        end
        rd_a_reg <= mem_a[addr_a];
    end

    always_ff @(posedge clk)
    begin
        if (mem_b_we)
        begin
            mem_b[addr_b] <= value;
        end
        rd_b_reg <= mem_b[addr_b];
    end

    assign mac_ctrl.clear = in_accept && !is_load;
    assign mac_ctrl.valid = rd_valid_reg;

    imp_mac u_mac
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (mac_ctrl),
        .a_data (rd_a_reg),
        .b_data (rd_b_reg),
        .busy   (mac_busy),
        .acc    (mac_acc)
    );

    assign load_out = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        count_next = count_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept && !is_load)
                begin
                    k_next = '0;
                    if (query_err)
                    begin
                        state_next = S_DONE;
                    end
                    else if (opcode == OP_ELEM)
                    begin
                        count_next = CFG_W'(1);
                        state_next = S_RUN;
                    end
                    else
                    begin
                        count_next = nk_lim;
                        state_next = (nk_lim == '0) ? S_DRAIN : S_RUN;
                    end
                end
            end
            S_RUN:
            begin
                k_next = k_reg + CFG_W'(1);
                if (k_next == count_reg)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                // wait for the read and multiply stages to empty
                if (!rd_valid_reg && !mac_busy)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            k_reg         <= '0;
            count_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            k_reg        <= k_next;
            count_reg    <= count_next;
            rd_valid_reg <= (state_reg == S_RUN);
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && !is_load)
        begin
            q_row_reg  <= row;
            q_col_reg  <= col;
            q_err_reg  <= query_err;
            q_elem_reg <= (opcode == OP_ELEM);
        end
        if (load_out)
        begin
            out_row_reg   <= q_row_reg;
            out_col_reg   <= q_col_reg;
            out_value_reg <= q_err_reg ? '0 : mac_acc;
            status_reg    <= q_err_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign out_value = out_value_reg;
    assign status    = status_reg;

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg) == S_DONE)
        else $error("result beat raised without a finished query");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status) |-> (out_value == '0))
        else $error("error result carries a nonzero value");

    a_k_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN) |-> (k_reg < count_reg))
        else $error("inner index ran past the iteration count");

    a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_a_we || mem_b_we) |-> (state_reg == S_IDLE && !rd_valid_reg))
        else $error("memory write during a query");

endmodule

// ----- src/imp_mac.sv -----
// ----------------------------------------------------------------------------
// imp_mac
// Shared multiply-accumulate unit: one registered 32x32 multiply feeding a
// wrapping 32-bit accumulator.
// ----------------------------------------------------------------------------
module imp_mac
    import imp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  mac_ctrl_t         ctrl,
    input  logic [DATA_W-1:0] a_data,
    input  logic [DATA_W-1:0] b_data,
    output logic              busy,
    output logic [DATA_W-1:0] acc
);

    logic              prod_valid_reg;
    logic [DATA_W-1:0] prod_reg;
    logic [DATA_W-1:0] acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
        end
        else if (ctrl.clear)
        begin
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= ctrl.valid;
        end
    end

    // low 32 bits of the product are the same for signed and unsigned operands
    always_ff @(posedge clk)
    begin
        prod_reg <= a_data * b_data;
        if (ctrl.clear)
        begin
            acc_reg <= '0;
        end
        else if (prod_valid_reg)
        begin
            acc_reg <= acc_reg + prod_reg;
        end
    end

    assign busy = prod_valid_reg;
    assign acc  = acc_reg;

endmodule
